// File: src/dmc_pkg.sv
package dmc_pkg;

    // Command kinds carried in s_tuser
    localparam logic [2:0] KIND_STOP  = 3'd0;
    localparam logic [2:0] KIND_STEP  = 3'd1;
    localparam logic [2:0] KIND_ANGLE = 3'd2;
    localparam logic [2:0] KIND_GOTO  = 3'd3;
    localparam logic [2:0] KIND_STORE = 3'd4;
    localparam logic [2:0] KIND_AUTO  = 3'd5;

    // Register indexes
    localparam logic REG_LON = 1'b0;
    localparam logic REG_LAT = 1'b1;

    // Message bytes
    localparam logic [7:0] FRAMING   = 8'hE0;
    localparam logic [7:0] ADDRESS   = 8'h31;
    localparam logic [7:0] CMD_STOP  = 8'h60;
    localparam logic [7:0] CMD_EAST  = 8'h68;
    localparam logic [7:0] CMD_WEST  = 8'h69;
    localparam logic [7:0] CMD_STORE = 8'h6A;
    localparam logic [7:0] CMD_GOTO  = 8'h6B;
    localparam logic [7:0] CMD_ANGLE = 8'h6E;
    localparam logic [3:0] DIR_NEG   = 4'hE;
    localparam logic [3:0] DIR_POS   = 4'hD;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;
    localparam logic [2:0] LEN_FIVE  = 3'd5;

    // Fixed point constants
    localparam int CORDIC_N = 30;
    localparam int ROOT_N   = 32;
    localparam logic [20:0] RAD_PER_TENTH = 21'd1874033;
    localparam logic signed [34:0] CORDIC_GAIN_INV = 35'sd652032874;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629712;
    localparam logic signed [34:0] LIMIT_65_Q30 = 35'sd1218121459;
    localparam logic [47:0] EARTH_R2_Q16 = 48'd40678884 << 16;
    localparam logic [23:0] ORBIT_Q8 = 24'd10794035;
    localparam logic [63:0] G31_SCALE = 64'd3555639523;
    localparam logic [63:0] TENTH_SCALE = 64'd37549362;

    localparam logic signed [34:0] ARC_TAB [CORDIC_N] = '{
        35'sh3243F6A8, 35'sh1DAC6705, 35'sh0FADBAFC, 35'sh07F56EA6, 35'sh03FEAB76,
        35'sh01FFD55B, 35'sh00FFFAAA, 35'sh007FFF55, 35'sh003FFFEA, 35'sh001FFFFD,
        35'sh000FFFFF, 35'sh0007FFFF, 35'sh0003FFFF, 35'sh0001FFFF, 35'sh0000FFFF,
        35'sh00007FFF, 35'sh00003FFF, 35'sh00001FFF, 35'sh00000FFF, 35'sh000007FF,
        35'sh000003FF, 35'sh000001FF, 35'sh000000FF, 35'sh0000007F, 35'sh0000003F,
        35'sh0000001F, 35'sh0000000F, 35'sh00000008, 35'sh00000004, 35'sh00000002
    };

    // USALS tenth-degree nibble
    localparam logic [3:0] TENTH_CODE [16] = '{
        4'h0, 4'h2, 4'h3, 4'h5, 4'h6, 4'h8, 4'hA, 4'hB,
        4'hD, 4'hE, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0
    };

    typedef struct packed {
        logic [63:0] rv;
        logic [63:0] rr;
    } root_t;

    typedef struct packed {
        logic [7:0]         cmd;
        logic [7:0]         b1;
        logic [7:0]         b2;
        logic [2:0]         len;
        logic               go;
        logic               neg;
        logic [10:0]        la;
        logic [10:0]        dl;
        logic signed [34:0] ax;
        logic signed [34:0] ay;
        logic signed [34:0] az;
        logic signed [34:0] bx;
        logic signed [34:0] by;
        logic signed [34:0] bz;
        logic [30:0]        sphi;
        logic [30:0]        cdel;
        logic [30:0]        sdel;
        logic [21:0]        g23;
        logic [21:0]        g25;
        logic [23:0]        tv;
        logic [23:0]        g28;
        logic [23:0]        g29;
        logic [47:0]        g23sq;
        logic [47:0]        p25;
        logic [47:0]        p26;
        logic [47:0]        tsq;
        logic [47:0]        p28;
        logic [47:0]        g29sq;
        logic [47:0]        g30sq;
        logic [47:0]        g31sq;
        logic [63:0]        rv;
        logic [63:0]        rr;
        logic signed [50:0] num;
        logic [49:0]        den;
        logic [32:0]        dr;
        logic [30:0]        dq;
        logic               cneg;
        logic               dzero;
        logic signed [31:0] cq;
        logic signed [34:0] vx;
        logic signed [34:0] vy;
        logic signed [34:0] vz;
        logic               zok;
        logic [10:0]        ttp;
    } stage_t;

    // x / 10 for x below 2048
    function automatic logic [7:0] div10(input logic [10:0] x);
        logic [24:0] m;
        m = 25'(x) * 25'd6554;
        return 8'(m >> 16);
    endfunction

    function automatic logic [30:0] clamp_unit(input logic signed [34:0] v);
        logic [30:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > 35'sh40000000)
        begin
            r = 31'h40000000;
        end
        else
        begin
            r = v[30:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] sub_floor0(input logic [47:0] a, input logic [47:0] b);
        return (a >= b) ? 64'(a - b) : 64'd0;
    endfunction

    // One digit of the exact floor square root
    function automatic root_t root_step(input root_t s, input int j);
        root_t n;
        logic [63:0] b;
        b = 64'd1 << (62 - 2 * j);
        if (s.rv >= s.rr + b)
        begin
            n.rv = s.rv - (s.rr + b);
            n.rr = (s.rr >> 1) + b;
        end
        else
        begin
            n.rv = s.rv;
            n.rr = s.rr >> 1;
        end
        return n;
    endfunction

    // Tenths above 1800 stand for negative angles
    function automatic logic signed [12:0] to_signed(input logic [11:0] v);
        return (v > 12'd1800) ? ($signed({1'b0, v}) - 13'sd3600) : $signed({1'b0, v});
    endfunction

endpackage

// File: src/diseqc_motor_command_encoder_unit.sv
// DiSEqC 1.2 / USALS positioner command encoder. Each input word is one
// command (kind on s_tuser) and gives exactly one output word: the 3 to 5
// byte motor message plus its length. The datapath is a fixed pipeline of
// 309 register stages from input to output, and one word can be taken every
// cycle while the output does not stall; that depth comes from the USALS path:
// two 30-step CORDIC rotators side by side, six 32-step square root units,
// a 31-step divider and a 30-step CORDIC arctangent in series. Every command
// kind travels the same path. The whole pipeline stalls together when the
// output word is not taken. Site longitude and latitude must only be written
// while no command is in flight.
module diseqc_motor_command_encoder_unit
    import dmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // position[11:0], slot_number[19:12], zero[23:20]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // framing[7:0], address[15:8], command[23:16],
                                   // data_one[31:24], data_two[39:32], length[42:40]
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);

    // Step boundaries along the pipeline
    localparam int K_THETA = 0;
    localparam int K_SC    = 1;
    localparam int K_CLAMP = K_SC + CORDIC_N;
    localparam int K_MUL1  = K_CLAMP + 1;
    localparam int K_SQ23  = K_MUL1 + 1;
    localparam int K_R24I  = K_SQ23 + 1;
    localparam int K_R24   = K_R24I + 1;
    localparam int K_G25   = K_R24 + ROOT_N;
    localparam int K_SQ    = K_G25 + 1;
    localparam int K_R26I  = K_SQ + 1;
    localparam int K_R26   = K_R26I + 1;
    localparam int K_P26   = K_R26 + ROOT_N;
    localparam int K_R27I  = K_P26 + 1;
    localparam int K_R27   = K_R27I + 1;
    localparam int K_G28   = K_R27 + ROOT_N;
    localparam int K_P28   = K_G28 + 1;
    localparam int K_R29I  = K_P28 + 1;
    localparam int K_R29   = K_R29I + 1;
    localparam int K_R30I  = K_R29 + ROOT_N;
    localparam int K_R30   = K_R30I + 1;
    localparam int K_DEN   = K_R30 + ROOT_N;
    localparam int K_NRM   = K_DEN + 1;
    localparam int NRM_N   = 5;
    localparam int K_DIVI  = K_NRM + NRM_N;
    localparam int K_DIV   = K_DIVI + 1;
    localparam int DIV_N   = 31;
    localparam int K_RSI   = K_DIV + DIV_N;
    localparam int K_RS    = K_RSI + 1;
    localparam int K_ATI   = K_RS + ROOT_N;
    localparam int K_AT    = K_ATI + 1;
    localparam int K_TT    = K_AT + CORDIC_N;
    localparam int K_OUT   = K_TT + 1;
    localparam int NS      = K_OUT + 1;

    function automatic stage_t pipe_step(input int k, input stage_t s);
        stage_t n;
        root_t rt;
        logic signed [34:0] dxa, dya, dxb, dyb;
        logic signed [50:0] dens, nm;
        logic signed [34:0] za;
        logic [63:0] m64;
        logic [32:0] r2;
        logic [7:0] wh;
        logic [3:0] rm;
        int i;
        int sh;
        n = s;
        rt.rv = s.rv;
        rt.rr = s.rr;
        if (k == K_THETA)
        begin
            n.ax = CORDIC_GAIN_INV;
            n.ay = '0;
            n.az = $signed(35'(s.la) * 35'(RAD_PER_TENTH));
            n.bx = CORDIC_GAIN_INV;
            n.by = '0;
            n.bz = $signed(35'(s.dl) * 35'(RAD_PER_TENTH));
        end
        else if (k >= K_SC && k < K_CLAMP)
        begin
            i = k - K_SC;
            dxa = s.ay >>> i;
            dya = s.ax >>> i;
            dxb = s.by >>> i;
            dyb = s.bx >>> i;
            if (!s.az[34])
            begin
                n.ax = s.ax - dxa;
                n.ay = s.ay + dya;
                n.az = s.az - ARC_TAB[i[4:0]];
            end
            else
            begin
                n.ax = s.ax + dxa;
                n.ay = s.ay - dya;
                n.az = s.az + ARC_TAB[i[4:0]];
            end
            if (!s.bz[34])
            begin
                n.bx = s.bx - dxb;
                n.by = s.by + dyb;
                n.bz = s.bz - ARC_TAB[i[4:0]];
            end
            else
            begin
                n.bx = s.bx + dxb;
                n.by = s.by - dyb;
                n.bz = s.bz + ARC_TAB[i[4:0]];
            end
        end
        else if (k == K_CLAMP)
        begin
            n.sphi = clamp_unit(s.ay);
            n.cdel = clamp_unit(s.bx);
            n.sdel = clamp_unit(s.by);
        end
        else if (k == K_MUL1)
        begin
            n.g23 = 22'((64'(s.sphi) * 64'd6378 + 64'd2097152) >> 22);
            n.g31sq = 48'((G31_SCALE * 64'(31'h40000000 - s.cdel) + 64'd8192) >> 14);
        end
        else if (k == K_SQ23)
        begin
            n.g23sq = 48'(s.g23) * 48'(s.g23);
        end
        else if (k == K_R24I)
        begin
            n.rv = sub_floor0(EARTH_R2_Q16, s.g23sq);
            n.rr = '0;
        end
        else if (k >= K_R24 && k < K_G25)
        begin
            rt = root_step(rt, k - K_R24);
            n.rv = rt.rv;
            n.rr = rt.rr;
        end
        else if (k == K_G25)
        begin
            n.g25 = 22'((64'(s.rr[21:0]) * 64'(s.sdel) + 64'd536870912) >> 30);
            n.tv = ORBIT_Q8 - 24'(s.rr[21:0]);
        end
        else if (k == K_SQ)
        begin
            n.p25 = 48'(s.g25) * 48'(s.g25);
            n.tsq = 48'(s.tv) * 48'(s.tv);
        end
        else if (k == K_R26I)
        begin
            n.rv = 64'(s.g23sq) + 64'(s.p25);
            n.rr = '0;
            n.g30sq = s.tsq + s.g23sq;
        end
        else if (k >= K_R26 && k < K_P26)
        begin
            rt = root_step(rt, k - K_R26);
            n.rv = rt.rv;
            n.rr = rt.rr;
        end
        else if (k == K_P26)
        begin
            n.p26 = 48'(s.rr[21:0]) * 48'(s.rr[21:0]);
        end
        else if (k == K_R27I)
        begin
            n.rv = sub_floor0(EARTH_R2_Q16, s.p26);
            n.rr = '0;
        end
        else if (k >= K_R27 && k < K_G28)
        begin
            rt = root_step(rt, k - K_R27);
            n.rv = rt.rv;
            n.rr = rt.rr;
        end
        else if (k == K_G28)
        begin
            n.g28 = ORBIT_Q8 - s.rr[23:0];
        end
        else if (k == K_P28)
        begin
            n.p28 = 48'(s.g28) * 48'(s.g28);
        end
        else if (k == K_R29I)
        begin
            n.g29sq = s.p28 + s.p26;
            n.rv = 64'(s.p28) + 64'(s.p26);
            n.rr = '0;
        end
        else if (k >= K_R29 && k < K_R30I)
        begin
            rt = root_step(rt, k - K_R29);
            n.rv = rt.rv;
            n.rr = rt.rr;
        end
        else if (k == K_R30I)
        begin
            n.g29 = s.rr[23:0];
            n.rv = 64'(s.g30sq);
            n.rr = '0;
        end
        else if (k >= K_R30 && k < K_DEN)
        begin
            rt = root_step(rt, k - K_R30);
            n.rv = rt.rv;
            n.rr = rt.rr;
        end
        else if (k == K_DEN)
        begin
            n.num = $signed(51'(s.g29sq)) + $signed(51'(s.g30sq)) - $signed(51'(s.g31sq));
            n.den = 50'({48'(s.g29) * 48'(s.rr[23:0]), 1'b0});
        end
        else if (k >= K_NRM && k < K_DIVI)
        begin
            // bring den below 2^32 by 16, 8, 4, 2, 1
            sh = 16 >> (k - K_NRM);
            if (s.den >= (50'd1 << (31 + sh)))
            begin
                n.den = s.den >> sh;
                n.num = s.num >>> sh;
            end
        end
        else if (k == K_DIVI)
        begin
            dens = $signed({1'b0, s.den});
            if (s.num > dens)
            begin
                nm = dens;
            end
            else if (s.num < -dens)
            begin
                nm = -dens;
            end
            else
            begin
                nm = s.num;
            end
            n.dzero = (s.den == '0);
            n.cneg = nm[50];
            n.dr = 33'(nm[50] ? -nm : nm);
            n.dq = '0;
        end
        else if (k >= K_DIV && k < K_RSI)
        begin
            i = (DIV_N - 1) - (k - K_DIV);
            r2 = (k == K_DIV) ? s.dr : {s.dr[31:0], 1'b0};
            if (r2 >= 33'(s.den))
            begin
                n.dr = r2 - 33'(s.den);
                n.dq[i[4:0]] = 1'b1;
            end
            else
            begin
                n.dr = r2;
            end
        end
        else if (k == K_RSI)
        begin
            n.cq = s.cneg ? -$signed(32'(s.dq)) : $signed(32'(s.dq));
            n.rv = 64'h1000_0000_0000_0000 - 64'(s.dq) * 64'(s.dq);
            n.rr = '0;
        end
        else if (k >= K_RS && k < K_ATI)
        begin
            rt = root_step(rt, k - K_RS);
            n.rv = rt.rv;
            n.rr = rt.rr;
        end
        else if (k == K_ATI)
        begin
            if (s.cq < 0)
            begin
                n.vx = $signed(35'(s.rr[30:0]));
                n.vy = -35'(s.cq);
                n.vz = HALF_PI_Q30;
            end
            else
            begin
                n.vx = 35'(s.cq);
                n.vy = $signed(35'(s.rr[30:0]));
                n.vz = '0;
            end
        end
        else if (k >= K_AT && k < K_TT)
        begin
            i = k - K_AT;
            dxa = s.vy >>> i;
            dya = s.vx >>> i;
            if (s.vy > 0)
            begin
                n.vx = s.vx + dxa;
                n.vy = s.vy - dya;
                n.vz = s.vz + ARC_TAB[i[4:0]];
            end
            else
            begin
                n.vx = s.vx - dxa;
                n.vy = s.vy + dya;
                n.vz = s.vz - ARC_TAB[i[4:0]];
            end
        end
        else if (k == K_TT)
        begin
            za = s.vz[34] ? -s.vz : s.vz;
            n.zok = (za <= LIMIT_65_Q30) && !s.dzero;
            m64 = 64'(za[33:0]) * TENTH_SCALE + (64'd1 << 45);
            n.ttp = 11'(m64 >> 46);
        end
        else if (k == K_OUT)
        begin
            if (s.go && s.zok && s.ttp != '0)
            begin
                wh = div10(s.ttp);
                rm = 4'(s.ttp - 11'(wh) * 11'd10);
                n.b1 = {s.neg ? DIR_NEG : DIR_POS, wh[7:4]};
                n.b2 = {wh[3:0], TENTH_CODE[rm]};
            end
        end
        return n;
    endfunction

    logic [11:0] lon_reg, lat_reg;
    logic [11:0] lon_next, lat_next;
    stage_t      st_reg  [NS + 1];
    stage_t      st_next [NS + 1];
    logic [NS:0] vld_reg, vld_next;
    logic        adv;
    stage_t      in_stage;

    assign adv      = !vld_reg[NS] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NS];
    assign m_tdata  = {5'd0, st_reg[NS].len, st_reg[NS].b2, st_reg[NS].b1,
                       st_reg[NS].cmd, ADDRESS, FRAMING};

    always_comb
    begin
        lon_next = lon_reg;
        lat_next = lat_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LON: lon_next = cfg_data;
                REG_LAT: lat_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lon_reg <= '0;
            lat_reg <= '0;
        end
        else
        begin
            lon_reg <= lon_next;
            lat_reg <= lat_next;
        end
    end

    // Command decode, fallback angle bytes and USALS sign
    always_comb
    begin
        logic [11:0]        pos;
        logic signed [12:0] p, lon, lat;
        logic signed [13:0] d;
        logic [12:0]        ad;
        logic [10:0]        ap;
        logic [7:0]         a;
        logic               ok;
        pos = s_tdata[11:0];
        p   = to_signed(pos);
        lon = to_signed(lon_reg);
        lat = to_signed(lat_reg);
        d   = 14'(p) - 14'(lon);
        ad  = 13'(d[13] ? -d : d);
        ap  = 11'(p[12] ? -p : p);
        a   = div10(ap);
        ok  = (lat >= -13'sd900) && (lat <= 13'sd900);
        in_stage = '0;
        in_stage.la  = 11'(lat[12] ? -lat : lat);
        in_stage.dl  = 11'((ad > 13'd1800) ? (13'd3600 - ad) : ad);
        in_stage.neg = !((p < lon && lat > 0) || (p > lon && lat < 0));
        if ((p < -13'sd899 && lon > 13'sd899) || (p > 13'sd899 && lon < -13'sd899))
        begin
            in_stage.neg = !in_stage.neg;
        end
        in_stage.cmd = CMD_STOP;
        in_stage.len = LEN_THREE;
        unique case (s_tuser)
            KIND_STEP:
            begin
                in_stage.len = LEN_FOUR;
                if (pos > 12'd1800)
                begin
                    in_stage.cmd = CMD_WEST;
                    in_stage.b1  = 8'(pos - 12'd3345);
                end
                else
                begin
                    in_stage.cmd = CMD_EAST;
                    in_stage.b1  = 8'hFF - pos[7:0];
                end
            end
            KIND_ANGLE, KIND_AUTO:
            begin
                in_stage.cmd = CMD_ANGLE;
                in_stage.len = LEN_FIVE;
                in_stage.b1  = {(p <= -13'sd10) ? DIR_NEG : DIR_POS, a[7:4]};
                in_stage.b2  = {a[3:0], 4'h0};
                in_stage.go  = (s_tuser == KIND_AUTO) && ok && (in_stage.dl <= 11'd650);
            end
            KIND_GOTO:
            begin
                in_stage.cmd = CMD_GOTO;
                in_stage.len = LEN_FOUR;
                in_stage.b1  = s_tdata[19:12];
            end
            KIND_STORE:
            begin
                in_stage.cmd = CMD_STORE;
                in_stage.len = LEN_FOUR;
                in_stage.b1  = s_tdata[19:12];
            end
            default:
            begin
                in_stage.cmd = CMD_STOP;
            end
        endcase
    end

    always_comb
    begin
        st_next[0] = in_stage;
        for (int j = 0; j < NS; j++)
        begin
            st_next[j + 1] = pipe_step(j, st_reg[j]);
        end
        vld_next = {vld_reg[NS-1:0], s_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

`ifndef SYNTHESIS
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[42:40] == LEN_THREE || m_tdata[42:40] == LEN_FOUR ||
                      m_tdata[42:40] == LEN_FIVE))
        else $error("message length out of range");

    a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[23:16] == CMD_STOP) |->
            (m_tdata[31:24] == 8'd0 && m_tdata[39:32] == 8'd0 &&
             m_tdata[42:40] == LEN_THREE))
        else $error("stop word carries data");

    a_angle_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[23:16] == CMD_ANGLE) |->
            (m_tdata[42:40] == LEN_FIVE &&
             (m_tdata[31:28] == DIR_NEG || m_tdata[31:28] == DIR_POS)))
        else $error("angle word malformed");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
